[design/ppp_pkg.sv]
`timescale 1ns / 1ps
package ppp_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int SCREEN_LIMIT = 8000;
	localparam int CFG_WIDTH = 64;
	localparam int NUM_REGS = 7;
	localparam int IDX_WIDTH = 3;
	localparam logic [IDX_WIDTH-1:0] REG_XROW_LIN = 3'd0;
	localparam logic [IDX_WIDTH-1:0] REG_XROW_ZOFF = 3'd1;
	localparam logic [IDX_WIDTH-1:0] REG_DEPTH_LIN = 3'd2;
	localparam logic [IDX_WIDTH-1:0] REG_DEPTH_ZOFF = 3'd3;
	localparam logic [IDX_WIDTH-1:0] REG_YROW_LIN = 3'd4;
	localparam logic [IDX_WIDTH-1:0] REG_YROW_ZOFF = 3'd5;
	localparam logic [IDX_WIDTH-1:0] REG_CENTER = 3'd6;
	// row value: products 64 bits signed, after shift 48, sum of 3 plus offset
	localparam int ROW_WIDTH = 52;
	// quotient magnitude width, wide enough to detect overflow
	localparam int QW = 34;
	// restoring divider: numerator bits (|row| << FRAC), ROW_WIDTH + FRAC_BITS wide
	localparam int NUM_WIDTH = ROW_WIDTH + FRAC_BITS;
endpackage

[design/perspective_point_projection.sv]
`timescale 1ns / 1ps
// channel  | direction | handshake                 | payload
// in       | input     | in_valid / in_ready       | point_x, point_y, point_z
// out      | output    | out_valid / out_ready     | screen_x, screen_y, depth, on_screen
// cfg      | input     | cfg_we                    | cfg_index, cfg_data
// one item per cycle unless a valid result waits on a low out_ready; an item passes
// stage 1, stage 2, stage 3, the divider stages and the output register
// the divider, four quotient bits per stage, sets the depth of the pipeline
// reset clears the config registers and valid bits; a stall freezes every stage at once
module perspective_point_projection #(
	parameter int FRAC_BITS = ppp_pkg::FRAC_BITS,
	parameter int SCREEN_LIMIT = ppp_pkg::SCREEN_LIMIT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ppp_pkg::IDX_WIDTH-1:0] cfg_index,
	input  logic [ppp_pkg::CFG_WIDTH-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] depth,
	output logic on_screen
);
	localparam int COORD_WIDTH = ppp_pkg::COORD_WIDTH;
	localparam int IW = ppp_pkg::IDX_WIDTH;
	localparam int RW = 34 + 48 - FRAC_BITS + 4;
	localparam int NW = RW + FRAC_BITS;
	localparam int QB = COORD_WIDTH + 1;
	localparam int BPS = 4;
	localparam int NST = (QB + BPS - 1) / BPS;
	localparam int LAT = 3 + NST;
	localparam logic signed [RW-1:0] SMAX = RW'((65'sd1 <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [RW-1:0] SMIN = -SMAX - RW'(1);
	localparam logic signed [RW-1:0] LIM = RW'(SCREEN_LIMIT) <<< FRAC_BITS;

	logic [ppp_pkg::CFG_WIDTH-1:0] regs_q [ppp_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{default: '0};
		end else if (cfg_we && 32'(cfg_index) < ppp_pkg::NUM_REGS) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	logic en;
	logic [LAT:0] v_q;
	assign en = !v_q[LAT] || out_ready;
	assign in_ready = en;
	assign out_valid = v_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-1:0], in_valid};
	end

	function automatic logic signed [31:0] hi(input logic [63:0] r);
		return r[63:32];
	endfunction
	function automatic logic signed [31:0] lo(input logic [63:0] r);
		return r[31:0];
	endfunction
	function automatic logic signed [RW-1:0] sat(input logic signed [RW-1:0] v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	// stage 1: nine products
	logic signed [63:0] p_s1 [3][3];
	logic signed [31:0] off_s1 [3];
	logic signed [31:0] cx_s1, cy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				p_s1[r][0] <= 64'(hi(regs_q[IW'(2*r)])) * 64'(point_x);
				p_s1[r][1] <= 64'(lo(regs_q[IW'(2*r)])) * 64'(point_y);
				p_s1[r][2] <= 64'(hi(regs_q[IW'(2*r+1)])) * 64'(point_z);
				off_s1[r] <= lo(regs_q[IW'(2*r+1)]);
			end
			cx_s1 <= hi(regs_q[ppp_pkg::REG_CENTER]);
			cy_s1 <= lo(regs_q[ppp_pkg::REG_CENTER]);
		end
	end

	// stage 2: row sums, the exact sum shifted right (floor) plus the offset
	logic signed [RW-1:0] row_s2 [3];
	logic signed [31:0] cx_s2, cy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				row_s2[r] <= RW'((66'(p_s1[r][0]) + 66'(p_s1[r][1]) + 66'(p_s1[r][2]))
					>>> FRAC_BITS) + RW'(off_s1[r]);
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
		end
	end

	// stage 3: magnitudes into dividers
	logic [NW-1:0] nx_s3, ny_s3;
	logic [RW-1:0] d_s3;
	logic negx_s3, negy_s3, pos_s3;
	logic signed [RW-1:0] dsat_s3;
	logic signed [31:0] cx_s3, cy_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			negx_s3 <= row_s2[0][RW-1];
			negy_s3 <= row_s2[2][RW-1];
			nx_s3 <= NW'(row_s2[0][RW-1] ? -row_s2[0] : row_s2[0]) << FRAC_BITS;
			ny_s3 <= NW'(row_s2[2][RW-1] ? -row_s2[2] : row_s2[2]) << FRAC_BITS;
			pos_s3 <= row_s2[1] > 0;
			d_s3 <= row_s2[1] > 0 ? row_s2[1] : RW'(1);
			dsat_s3 <= sat(row_s2[1]);
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
		end
	end

	logic [QB-1:0] qx, qy;
	logic ox, oy;
	ppp_div #(.NW(NW), .DW(RW), .QBITS(QB), .BPS(BPS)) u_divx (
		.clk(clk), .en(en), .num(nx_s3), .den(d_s3), .quo(qx), .ovf(ox));
	ppp_div #(.NW(NW), .DW(RW), .QBITS(QB), .BPS(BPS)) u_divy (
		.clk(clk), .en(en), .num(ny_s3), .den(d_s3), .quo(qy), .ovf(oy));

	// side data delay line alongside divider
	typedef struct packed {
		logic negx, negy, pos;
		logic signed [RW-1:0] dsat;
		logic signed [31:0] cx, cy;
	} side_t;
	side_t sd_in;
	side_t sd_q [1:NST];
	assign sd_in = '{negx: negx_s3, negy: negy_s3, pos: pos_s3, dsat: dsat_s3,
		cx: cx_s3, cy: cy_s3};
	for (genvar g = 1; g <= NST; g++) begin : g_sd
		if (g == 1) begin : g_head
			always_ff @(posedge clk) if (en) sd_q[g] <= sd_in;
		end else begin : g_link
			always_ff @(posedge clk) if (en) sd_q[g] <= sd_q[g-1];
		end
	end
	side_t sd;
	assign sd = sd_q[NST];

	// final stage: sign, saturate, centre adjust, flag
	logic signed [RW-1:0] qsx, qsy, sx, sy, cxs, cys;
	always_comb begin
		qsx = (ox || RW'(qx) > SMAX) ? (sd.negx ? SMIN : SMAX)
			: (sd.negx ? -RW'(qx) : RW'(qx));
		qsy = (oy || RW'(qy) > SMAX) ? (sd.negy ? SMIN : SMAX)
			: (sd.negy ? -RW'(qy) : RW'(qy));
		cxs = sat(RW'(sd.cx));
		cys = sat(RW'(sd.cy));
		sx = sat(cxs + qsx);
		sy = sat(cys - qsy);
	end

	logic signed [31:0] sx_q, sy_q, d_q;
	logic on_q;
	always_ff @(posedge clk) begin
		if (en) begin
			sx_q <= sd.pos ? 32'(sx) : '0;
			sy_q <= sd.pos ? 32'(sy) : '0;
			d_q <= 32'(sd.dsat);
			on_q <= sd.pos && sx > -LIM && sx < LIM && sy > -LIM && sy < LIM;
		end
	end
	assign screen_x = sx_q;
	assign screen_y = sy_q;
	assign depth = d_q;
	assign on_screen = on_q;
endmodule

[design/ppp_div.sv]
`timescale 1ns / 1ps
module ppp_div #(
	parameter int NW = ppp_pkg::NUM_WIDTH,
	parameter int DW = ppp_pkg::ROW_WIDTH,
	parameter int QBITS = ppp_pkg::QW,
	parameter int BPS = 4
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QBITS-1:0] quo,
	output logic          ovf
);
	// numerator >= den << QBITS means saturation; otherwise QBITS restoring steps
	localparam int NST = (QBITS + BPS - 1) / BPS;
	localparam int RW = DW + 1;

	logic [NW-1:0]    n_s [1:NST];
	logic [DW-1:0]    d_s [1:NST];
	logic [QBITS-1:0] q_s [1:NST];
	logic [RW-1:0]    r_s [1:NST];
	logic             o_s [1:NST];

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic [NW-1:0]    n_i;
		logic [DW-1:0]    d_i;
		logic [QBITS-1:0] q_i;
		logic [RW-1:0]    r_i;
		logic             o_i;
		logic [QBITS-1:0] q_c;
		logic [RW-1:0]    r_c;
		if (g == 0) begin : g_head
			// upper numerator bits seed the remainder
			assign n_i = num;
			assign d_i = den;
			assign q_i = '0;
			assign r_i = RW'(num >> QBITS);
			assign o_i = ({{QBITS{1'b0}}, num} >> QBITS) >= {{(NW+QBITS-DW){1'b0}}, den};
		end else begin : g_link
			assign n_i = n_s[g];
			assign d_i = d_s[g];
			assign q_i = q_s[g];
			assign r_i = r_s[g];
			assign o_i = o_s[g];
		end
		always_comb begin
			logic [RW:0] t;
			logic [QBITS-1:0] nq;
			t = '0;
			nq = n_i[QBITS-1:0] << (g * BPS);
			q_c = q_i;
			r_c = r_i;
			for (int k = 0; k < BPS; k++) begin
				if (g * BPS + k < QBITS) begin
					t = {r_c, nq[QBITS-1]};
					nq = nq << 1;
					q_c = {q_c[QBITS-2:0], 1'b0};
					if (t >= {2'b0, d_i}) begin
						t = t - {2'b0, d_i};
						q_c[0] = 1'b1;
					end
					r_c = t[RW-1:0];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[g+1] <= n_i;
				d_s[g+1] <= d_i;
				q_s[g+1] <= q_c;
				r_s[g+1] <= r_c;
				o_s[g+1] <= o_i;
			end
		end
	end

	assign quo = q_s[NST];
	assign ovf = o_s[NST];
endmodule
